>>> src/igfc_pkg.sv
// Package for the idle-gap frame collector: shared types and constants.
// Used by igfc_front, igfc_back and idle_gap_frame_collector_unit.
// No dependencies.
`default_nettype none

package igfc_pkg;

    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned ADDR_W      = 6;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned IDLE_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CMD_DEPTH   = 2;
    localparam int unsigned OUT_DEPTH   = 4;

    localparam logic [IDLE_W-1:0] IDLE_SAT   = 16'hFFFF;
    localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd3;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic                wr;
        logic [BYTE_W-1:0]   data;
        logic [ADDR_W-1:0]   addr;
        logic                emit;
        logic [LEN_W-1:0]    len;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                last;
    } t_out;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

>>> src/idle_gap_frame_collector_unit.sv
// Top level of the idle-gap frame collector: front end, command queue, back end.
// Depends on igfc_pkg, igfc_queue, igfc_front and igfc_back.
//
//   channel   direction  handshake             payload
//   request   in         push / full           i_kind, i_rx_byte, i_buffer_free
//   result    out        empty / pop           o_frame_byte, o_frame_last
//   config    in         i_cfg_we              i_cfg_wdata (idle_limit)
//
// A request is taken while the two-entry command queue has room.
// A closing frame of L bytes drains from the frame store at one byte per cycle
// (one store read port) while the result queue has room; requests behind it
// wait in the command queue and full rises once two are waiting.
// Reset is synchronous, active low; idle_limit resets to 3. Result stalls back up
// through a four-entry result queue into the drain and then into full.
`default_nettype none

module idle_gap_frame_collector_unit #(
    parameter int unsigned FRAME_MAX = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [igfc_pkg::IDLE_W-1:0]   i_cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_kind,
    input  wire logic [igfc_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                          i_buffer_free,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [igfc_pkg::BYTE_W-1:0]        o_frame_byte,
    output logic                               o_frame_last
);

    logic           accept;
    logic           cmd_push;
    igfc_pkg::t_cmd cmd_in;
    igfc_pkg::t_cmd cmd_head;
    logic           cmd_empty;
    logic           cmd_pop;

    assign accept = push && !full;

    igfc_front #(
        .FRAME_MAX (FRAME_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_rx_byte     (i_rx_byte),
        .i_buffer_free (i_buffer_free),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in)
    );

    igfc_queue #(
        .WIDTH ($bits(igfc_pkg::t_cmd)),
        .DEPTH (igfc_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head),
        .o_count ()
    );

    igfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (cmd_empty),
        .i_cmd        (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

>>> src/igfc_queue.sv
// Small register-based FIFO with full/empty flags and an occupancy count.
// Used for the command queue and the result queue; no dependencies.
`default_nettype none

module igfc_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [WIDTH-1:0]                  o_data,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> src/igfc_front.sv
// Front end: accepts byte and tick requests, tracks frame length and idle count,
// decides frame close and issues store/emit commands. Depends on igfc_pkg.
`default_nettype none

module igfc_front #(
    parameter int unsigned FRAME_MAX = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [igfc_pkg::IDLE_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_accept,
    input  wire logic                          i_kind,
    input  wire logic [igfc_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                          i_buffer_free,
    output logic                               o_cmd_push,
    output igfc_pkg::t_cmd                     o_cmd
);

    localparam int unsigned LW = igfc_pkg::LEN_W;
    localparam int unsigned IW = igfc_pkg::IDLE_W;

    logic [IW-1:0] r_idle_limit;
    logic [IW-1:0] r_idle,  n_idle;
    logic [LW-1:0] r_len,   n_len;
    logic [LW-1:0] len_inc;
    logic          close;

    assign len_inc = r_len + LW'(1);

    always_comb begin
        n_idle = r_idle;
        n_len  = r_len;
        close  = 1'b0;
        o_cmd  = '0;
        o_cmd_push = 1'b0;
        if (i_accept) begin
            unique case (igfc_pkg::t_kind'(i_kind))
                igfc_pkg::KIND_BYTE: begin
                    n_idle     = '0;
                    close      = (len_inc == LW'(FRAME_MAX));
                    n_len      = close ? '0 : len_inc;
                    o_cmd.wr   = 1'b1;
                    o_cmd.data = i_rx_byte;
                    o_cmd.addr = r_len[igfc_pkg::ADDR_W-1:0];
                    o_cmd.emit = close && i_buffer_free;
                    o_cmd.len  = len_inc;
                    o_cmd_push = 1'b1;
                end
                igfc_pkg::KIND_TICK: begin
                    n_idle     = (r_idle == igfc_pkg::IDLE_SAT) ? r_idle : r_idle + IW'(1);
                    close      = (r_len != '0) && (n_idle > r_idle_limit);
                    n_len      = close ? '0 : r_len;
                    o_cmd.emit = close && i_buffer_free;
                    o_cmd.len  = r_len;
                    o_cmd_push = close && i_buffer_free;
                end
                default: begin
                    n_idle = r_idle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= igfc_pkg::IDLE_RESET;
            r_idle       <= '0;
            r_len        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            r_idle <= n_idle;
            r_len  <= n_len;
        end
    end

endmodule

`default_nettype wire

>>> src/igfc_back.sv
// Back end: frame store memory, command execution and byte-by-byte drain
// into the result queue. Depends on igfc_pkg and igfc_queue.
`default_nettype none

module igfc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_empty,
    input  wire igfc_pkg::t_cmd                i_cmd,
    output logic                               o_cmd_pop,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [igfc_pkg::BYTE_W-1:0]        o_frame_byte,
    output logic                               o_frame_last
);

    localparam int unsigned LW = igfc_pkg::LEN_W;
    localparam int unsigned AW = igfc_pkg::ADDR_W;
    localparam int unsigned OD = igfc_pkg::OUT_DEPTH;
    localparam int unsigned CW = $clog2(OD + 1);

    igfc_pkg::t_back_state r_state, n_state;

    logic [igfc_pkg::BYTE_W-1:0] r_store [igfc_pkg::STORE_DEPTH];
    logic [LW-1:0]               r_idx;
    logic [LW-1:0]               r_len;
    logic [igfc_pkg::BYTE_W-1:0] r_rd_data;
    logic                        r_rd_last;
    logic                        r_rd_pend;
    logic                        mem_we;
    logic                        issue;
    logic                        last_idx;
    logic [CW-1:0]               out_count;
    logic [CW-1:0]               used;
    igfc_pkg::t_out              out_in;
    igfc_pkg::t_out              out_head;

    assign last_idx = ((r_idx + LW'(1)) == r_len);
    assign used     = out_count + CW'(r_rd_pend);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            igfc_pkg::BK_IDLE: begin
                if (!i_cmd_empty && i_cmd.emit) begin
                    n_state = igfc_pkg::BK_EMIT;
                end
            end
            igfc_pkg::BK_EMIT: begin
                if (issue && last_idx) begin
                    n_state = igfc_pkg::BK_IDLE;
                end
            end
            default: n_state = igfc_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        unique case (r_state)
            igfc_pkg::BK_IDLE: o_cmd_pop = !i_cmd_empty;
            igfc_pkg::BK_EMIT: issue     = (used < CW'(OD));
            default: o_cmd_pop = 1'b0;
        endcase
    end

    assign mem_we = o_cmd_pop && i_cmd.wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= igfc_pkg::BK_IDLE;
            r_rd_pend <= 1'b0;
            r_idx     <= '0;
            r_len     <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= issue;
            if (o_cmd_pop && i_cmd.emit) begin
                r_idx <= '0;
                r_len <= i_cmd.len;
            end else if (issue) begin
                r_idx <= r_idx + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[i_cmd.addr] <= i_cmd.data;
        end
        if (issue) begin
            r_rd_data <= r_store[r_idx[AW-1:0]];
            r_rd_last <= last_idx;
        end
    end

    assign out_in.data = r_rd_data;
    assign out_in.last = r_rd_last;

    igfc_queue #(
        .WIDTH ($bits(igfc_pkg::t_out)),
        .DEPTH (OD)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rd_pend),
        .i_data  (out_in),
        .o_full  (),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (out_head),
        .o_count (out_count)
    );

    assign o_frame_byte = out_head.data;
    assign o_frame_last = out_head.last;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Testbench for idle_gap_frame_collector_unit: drives byte and tick requests,
// predicts the emitted frames and checks every frame byte and last mark.
// Depends on igfc_pkg and the RTL of idle_gap_frame_collector_unit.
`timescale 1ns / 100ps

module testbench;

    localparam int FRAME_MAX    = 64;
    localparam int SILENCE_SAT  = 65535;
    localparam int SETTLE       = 160;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int BW           = igfc_pkg::BYTE_W;
    localparam int IW           = igfc_pkg::IDLE_W;

    typedef struct {
        igfc_pkg::t_kind    kind;
        logic [BW-1:0]      data;
        logic               free;
    } t_uart_req;

    typedef struct {
        logic [BW-1:0]      data;
        logic               last;
    } t_frame_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IW-1:0]      i_cfg_wdata = '0;
    logic               push = 1'b0;
    logic               full;
    logic               i_kind = 1'b0;
    logic [BW-1:0]      i_rx_byte = '0;
    logic               i_buffer_free = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [BW-1:0]      o_frame_byte;
    logic               o_frame_last;

    t_uart_req          pending_reqs[$];
    t_uart_req          req_on_bus;
    t_frame_out         frame_bytes_due[$];
    t_frame_out         due;

    logic [BW-1:0]      frame_buf [0:FRAME_MAX-1];
    int                 frame_len = 0;
    int                 silent_ticks = 0;
    logic [IW-1:0]      idle_limit_now = igfc_pkg::IDLE_RESET;

    int                 send_idle_pct = 0;
    int                 take_idle_pct = 0;
    logic               hold_trigger = 1'b0;
    logic               hold_taken = 1'b0;
    int                 hold_left = 0;

    int                 cycles = 0;
    int                 mismatches = 0;
    int                 reqs_taken = 0;
    int                 bytes_checked = 0;
    int                 limits_used = 0;

    idle_gap_frame_collector_unit #(
        .FRAME_MAX(FRAME_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push(push),
        .full(full),
        .i_kind(i_kind),
        .i_rx_byte(i_rx_byte),
        .i_buffer_free(i_buffer_free),
        .empty(empty),
        .pop(pop),
        .o_frame_byte(o_frame_byte),
        .o_frame_last(o_frame_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void close_frame(input logic free);
        t_frame_out o;
        if (free) begin
            for (int i = 0; i < frame_len; i++) begin
                o.data = frame_buf[i];
                o.last = (i == frame_len - 1);
                frame_bytes_due.push_back(o);
            end
        end
        frame_len = 0;
    endfunction

    function automatic void collect_req(input t_uart_req r);
        if (r.kind == igfc_pkg::KIND_BYTE) begin
            silent_ticks = 0;
            if (frame_len < FRAME_MAX) begin
                frame_buf[frame_len] = r.data;
                frame_len++;
            end
            if (frame_len >= FRAME_MAX)
                close_frame(r.free);
        end else begin
            if (silent_ticks < SILENCE_SAT)
                silent_ticks++;
            if (frame_len != 0 && silent_ticks > idle_limit_now)
                close_frame(r.free);
        end
    endfunction

    task automatic add_req(input igfc_pkg::t_kind k, input logic [BW-1:0] d, input logic f);
        t_uart_req r;
        r.kind = k;
        r.data = d;
        r.free = f;
        pending_reqs.push_back(r);
    endtask

    // well-formed frames with random content, plus broken gaps and stray ticks
    task automatic add_random_frames(input int want);
        int added;
        int len;
        int ticks;
        added = 0;
        while (added < want) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(FRAME_MAX, 20) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
                add_req(igfc_pkg::KIND_BYTE, BW'($urandom_range(255)), $urandom_range(3) != 0);
            if ($urandom_range(9) < 7)
                ticks = idle_limit_now + 1 + $urandom_range(2);
            else
                ticks = $urandom_range(idle_limit_now);
            for (int i = 0; i < ticks; i++)
                add_req(igfc_pkg::KIND_TICK, BW'($urandom_range(255)), $urandom_range(3) != 0);
            added += len + ticks;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || push || frame_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [IW-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        idle_limit_now = v;
        limits_used++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // driver: hold a request until taken, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                collect_req(req_on_bus);
                reqs_taken++;
            end
            if (!push || !full) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_on_bus = pending_reqs.pop_front();
                    push <= 1'b1;
                    i_kind <= req_on_bus.kind;
                    i_rx_byte <= req_on_bus.data;
                    i_buffer_free <= req_on_bus.free;
                end else begin
                    push <= 1'b0;
                    i_kind <= 1'($urandom_range(1));
                    i_rx_byte <= BW'($urandom_range(255));
                    i_buffer_free <= 1'($urandom_range(1));
                end
            end
        end
    end

    // monitor: check each frame byte against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                bytes_checked++;
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected frame_byte %02h frame_last %0b", o_frame_byte, o_frame_last);
                    mismatches++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (o_frame_byte !== due.data) begin
                        $error("frame_byte expected %02h actual %02h", due.data, o_frame_byte);
                        mismatches++;
                    end
                    if (o_frame_last !== due.last) begin
                        $error("frame_last expected %0b actual %0b", due.last, o_frame_last);
                        mismatches++;
                    end
                end
            end
            if (hold_trigger && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[idle_gap_frame_collector_unit] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 30;
        take_idle_pct = 86;
        add_req(igfc_pkg::KIND_BYTE, 8'h00, 1'b1);
        add_req(igfc_pkg::KIND_BYTE, 8'hFF, 1'b1);
        add_req(igfc_pkg::KIND_BYTE, 8'hA5, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'hFF, 1'b0);
        add_req(igfc_pkg::KIND_TICK, 8'hFF, 1'b0);
        add_req(igfc_pkg::KIND_TICK, 8'hFF, 1'b0);
        add_req(igfc_pkg::KIND_TICK, 8'h00, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'h7E, 1'b1);
        add_req(igfc_pkg::KIND_BYTE, 8'h5A, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'h81, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'h42, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'h18, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'hE7, 1'b0);
        add_random_frames(70);
        wait_drained();

        send_idle_pct = 86;
        take_idle_pct = 30;
        write_idle_limit(16'd0);
        add_req(igfc_pkg::KIND_BYTE, 8'h3C, 1'b0);
        add_req(igfc_pkg::KIND_TICK, 8'hC3, 1'b1);
        add_req(igfc_pkg::KIND_BYTE, 8'hC3, 1'b1);
        add_req(igfc_pkg::KIND_TICK, 8'h3C, 1'b0);
        add_random_frames(70);
        wait_drained();

        send_idle_pct = 0;
        take_idle_pct = 0;
        write_idle_limit(IW'($urandom_range(6, 1)));
        add_random_frames(70);
        hold_trigger <= 1'b1;
        wait_drained();

        write_idle_limit(16'd65534);
        for (int i = 0; i < FRAME_MAX; i++)
            add_req(igfc_pkg::KIND_BYTE, BW'($urandom_range(255)),
                    (i == FRAME_MAX - 1) || $urandom_range(1));
        for (int i = 0; i < FRAME_MAX; i++)
            add_req(igfc_pkg::KIND_BYTE, BW'($urandom_range(255)),
                    (i != FRAME_MAX - 1) && $urandom_range(1));
        add_req(igfc_pkg::KIND_BYTE, BW'($urandom_range(255)), 1'b0);
        for (int i = 0; i < 4; i++)
            add_req(igfc_pkg::KIND_TICK, BW'($urandom_range(255)), 1'b1);
        wait_drained();

        write_idle_limit(16'd0);
        add_req(igfc_pkg::KIND_TICK, BW'($urandom_range(255)), 1'b1);
        wait_drained();

        $display("run took %0d requests and checked %0d frame bytes", reqs_taken, bytes_checked);
        $display("idle_limit written %0d times, down to 0 and up to 65534", limits_used);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("[idle_gap_frame_collector_unit] OK");
        else
            $display("[idle_gap_frame_collector_unit] ERROR");
        $finish;
    end

endmodule
